// ----- sv/tpkd_pkg.sv -----
// Shared types and constants for the tick pulse and key debounce block.
// No dependencies; every other file in this folder imports this package.
package tpkd_pkg;

  localparam int SAMPLE_RATE = 20000;

  // Interval thresholds in sample counts.
  localparam int THR_10MS  = SAMPLE_RATE / 100;
  localparam int THR_50MS  = SAMPLE_RATE / 50;
  localparam int THR_100MS = SAMPLE_RATE / 10;
  localparam int THR_500MS = SAMPLE_RATE / 2;

  localparam int COUNT_W = 15;
  localparam int LIMIT_W = 8;
  localparam int TALLY_W = 4;
  localparam logic [TALLY_W-1:0] TALLY_WRAP = TALLY_W'(10);

  // A stored firing point lies between -SAMPLE_RATE and the largest counter value.
  localparam int COUNT_SPAN = (SAMPLE_RATE > (1 << COUNT_W)) ? SAMPLE_RATE : (1 << COUNT_W);
  localparam int LAST_W     = $clog2(COUNT_SPAN) + 1;
  // Elapsed counts, including the wrap correction, stay within four times that span.
  localparam int DIFF_W     = LAST_W + 2;

  typedef struct packed {
    logic [COUNT_W-1:0] sample_count;
    logic               enable_switch;
    logic               reset_switch;
  } in_t;

  typedef struct packed {
    logic tick_10ms;
    logic tick_50ms;
    logic tick_100ms;
    logic tick_500ms;
    logic tick_1s;
    logic enable_pressed;
    logic reset_pressed;
  } out_t;

endpackage

// ----- sv/tick_pulse_and_key_debounce.sv -----
// Top level: timebase pulse generator with two-switch debounce.
// Depends on tpkd_pkg, tpkd_tracker and tpkd_debounce.
//
//  port group   direction  contents
//  in_*         in         one loop pass: sample counter and two raw switch levels
//  out_*        out        one result per pass: five tick pulses, two press events
//  cfg_*        in         debounce limit write, no read-back
//
// A request is registered in the input register on entry and its result is then
// registered in the output register as the request advances; one request is taken
// every cycle while the output does not stall.
// Tracker and debounce state move only when a request passes from the input
// register to the output register. A stalled output holds both registers while
// the input still fills an empty input register. Synchronous reset clears the valid
// flags and all tally, tracker and debounce state and sets the debounce limit to 10.
module tick_pulse_and_key_debounce (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tpkd_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tpkd_pkg::out_t               out_data,
  input  logic                         cfg_we,
  input  logic [tpkd_pkg::LIMIT_W-1:0] cfg_wdata
);
  import tpkd_pkg::*;

  logic               in_valid_r;
  in_t                in_data_r;
  logic               out_valid_r;
  out_t               out_data_r;
  out_t               out_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [TALLY_W-1:0] tally_r;
  logic [TALLY_W-1:0] tally_nxt;
  logic [TALLY_W-1:0] tally_inc;
  logic               advance;
  logic               t10;
  logic               t50;
  logic               t100;
  logic               t500;
  logic               t1s;
  logic               en_ev;
  logic               rst_ev;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tpkd_tracker u_trk_10ms (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .now       (in_data_r.sample_count),
    .threshold (DIFF_W'(THR_10MS)),
    .tick      (t10)
  );

  tpkd_tracker u_trk_50ms (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .now       (in_data_r.sample_count),
    .threshold (DIFF_W'(THR_50MS)),
    .tick      (t50)
  );

  tpkd_tracker u_trk_100ms (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .now       (in_data_r.sample_count),
    .threshold (DIFF_W'(THR_100MS)),
    .tick      (t100)
  );

  tpkd_tracker u_trk_500ms (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .now       (in_data_r.sample_count),
    .threshold (DIFF_W'(THR_500MS)),
    .tick      (t500)
  );

  tpkd_debounce u_deb_enable (
    .clk         (clk),
    .rst_n       (rst_n),
    .sample_en   (advance && t10),
    .pressed     (in_data_r.enable_switch),
    .limit       (limit_r),
    .press_event (en_ev)
  );

  tpkd_debounce u_deb_reset (
    .clk         (clk),
    .rst_n       (rst_n),
    .sample_en   (advance && t10),
    .pressed     (in_data_r.reset_switch),
    .limit       (limit_r),
    .press_event (rst_ev)
  );

  // One-second tally counts 100 ms pulses and rolls over on the tenth.
  always_comb begin
    tally_inc = tally_r + TALLY_W'(1);
    t1s       = 1'b0;
    tally_nxt = tally_r;
    if (t100) begin
      if (tally_inc == TALLY_WRAP) begin
        t1s       = 1'b1;
        tally_nxt = '0;
      end else begin
        tally_nxt = tally_inc;
      end
    end
  end

  always_comb begin
    out_nxt.tick_10ms      = t10;
    out_nxt.tick_50ms      = t50;
    out_nxt.tick_100ms     = t100;
    out_nxt.tick_500ms     = t500;
    out_nxt.tick_1s        = t1s;
    out_nxt.enable_pressed = en_ev;
    out_nxt.reset_pressed  = rst_ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tally_r     <= '0;
      limit_r     <= LIMIT_W'(10);
    end else begin
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        tally_r     <= tally_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_nxt;
    end
  end

endmodule

// ----- sv/tpkd_tracker.sv -----
// One interval tracker: holds the counter value of its last firing and pulses
// when the counter has advanced past the threshold. Depends on tpkd_pkg.
module tpkd_tracker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [tpkd_pkg::COUNT_W-1:0] now,
  input  logic [tpkd_pkg::DIFF_W-1:0]  threshold,
  output logic                         tick
);
  import tpkd_pkg::*;

  localparam logic signed [DIFF_W-1:0] RATE_S = DIFF_W'(SAMPLE_RATE);

  logic signed [LAST_W-1:0] last_r;
  logic signed [LAST_W-1:0] last_nxt;
  logic signed [DIFF_W-1:0] now_s;
  logic signed [DIFF_W-1:0] last_s;
  logic signed [DIFF_W-1:0] elapsed;
  logic signed [DIFF_W-1:0] elapsed_adj;
  logic signed [DIFF_W-1:0] last_wrap;
  logic                     wrapped;

  always_comb begin
    now_s       = signed'({{(DIFF_W-COUNT_W){1'b0}}, now});
    last_s      = signed'({{(DIFF_W-LAST_W){last_r[LAST_W-1]}}, last_r});
    elapsed     = now_s - last_s;
    wrapped     = elapsed[DIFF_W-1];
    // The counter wrapped below the last firing point: move that point back one period.
    last_wrap   = last_s - RATE_S;
    elapsed_adj = wrapped ? (elapsed + RATE_S) : elapsed;
    tick        = elapsed_adj > signed'(threshold);
    if (tick) begin
      last_nxt = signed'(now_s[LAST_W-1:0]);
    end else if (wrapped) begin
      last_nxt = signed'(last_wrap[LAST_W-1:0]);
    end else begin
      last_nxt = last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (advance) begin
      last_r <= last_nxt;
    end
  end

endmodule

// ----- sv/tpkd_debounce.sv -----
// Debounce counter for one switch: counts consecutive pressed samples and
// flags the sample that reaches the limit. Depends on tpkd_pkg.
module tpkd_debounce (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         sample_en,
  input  logic                         pressed,
  input  logic [tpkd_pkg::LIMIT_W-1:0] limit,
  output logic                         press_event
);
  import tpkd_pkg::*;

  logic [LIMIT_W-1:0] hold_r;
  logic [LIMIT_W-1:0] hold_nxt;
  logic [LIMIT_W-1:0] hold_inc;
  logic               can_inc;

  always_comb begin
    hold_inc    = hold_r + LIMIT_W'(1);
    // The count stops one above the limit, or at the all-ones value, so that a held switch reports once.
    can_inc     = (hold_r <= limit) && (hold_r != '1);
    press_event = 1'b0;
    hold_nxt    = hold_r;
    if (sample_en) begin
      if (!pressed) begin
        hold_nxt = '0;
      end else if (can_inc) begin
        hold_nxt    = hold_inc;
        press_event = (hold_inc == limit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0;
    end else begin
      hold_r <= hold_nxt;
    end
  end

endmodule
